### design/frc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

    localparam int CAPACITY    = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int FILL_W      = $clog2(CAPACITY + 1);
    localparam int AGE_W       = 32;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_PUT    = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] POL_LFU  = 2'd0;
    localparam logic [1:0] POL_MFU  = 2'd1;
    localparam logic [1:0] POL_MFRU = 2'd2;
    localparam logic [1:0] POL_LFRU = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_HFIND_RD,
        ST_HFIND_CHK,
        ST_VIC_RD,
        ST_VIC_CHK,
        ST_VSLOT_RD,
        ST_VSLOT_CHK,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_SD_RD,
        ST_SD_RD2,
        ST_SD_CHK,
        ST_SD_RD3,
        ST_SD_SWAP,
        ST_AGE_RD,
        ST_AGE_WR,
        ST_INS_WR,
        ST_SU_RD,
        ST_SU_RD2,
        ST_SU_CHK,
        ST_SLOT_WR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0]       hslot;
        logic [COUNT_WIDTH-1:0] count;
        logic [AGE_W-1:0]       age;
    } hrec_t;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] data;
        logic        dirty;
    } slot_t;

endpackage

`default_nettype wire

### design/frequency_replacement_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports           | word
// request   | s_axis_*        | tdata: cmd, address, wdata (66 bits, padded to 72)
// result    | m_axis_*        | tdata: hit, rdata, evicted, evict_address, evict_data,
//           |                 |        evict_dirty (99 bits, padded to 104)
// policy    | cfg_we, cfg_wdata | replace_policy
//
// One request at a time; every step of a scan or sift waits on a registered memory read.
// An unused command goes straight to the output; a miss that evicts under MFRU or LFRU
// runs a slot scan, a victim scan, a delete, a sift down, an ageing pass, an insert and
// sift up, then the slot write and the output.
// Reset clears control state, the policy and the fill level only; no clearing pass.
// s_axis_tready stays low during reset.
// A finished result waits in the output register while the input stays stalled.

module frequency_replacement_cache_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [71:0]  s_axis_tdata,   // cmd[1:0], address[33:2], wdata[65:34]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic      [103:0] m_axis_tdata,   // hit[0], rdata[32:1], evicted[33],
                                              // evict_address[65:34], evict_data[97:66],
                                              // evict_dirty[98]
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_wdata
);

    localparam int IW = frc_pkg::IDX_W;
    localparam int FW = frc_pkg::FILL_W;
    localparam int CW = frc_pkg::COUNT_WIDTH;
    localparam int HW = $bits(frc_pkg::hrec_t);
    localparam int SW = $bits(frc_pkg::slot_t);
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [FW-1:0] CAP = FW'(frc_pkg::CAPACITY);

    frc_pkg::state_t state_reg, state_next;

    logic [1:0]  policy_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [1:0]  cmd_reg;
    logic [31:0] addr_reg, wdata_reg;
    logic [FW-1:0] i_reg, i_next;          // scan index
    logic [FW-1:0] j_reg, j_next;          // child / parent index
    logic [FW-1:0] h_reg, h_next;          // heap position of accessed record
    logic [IW-1:0] slot_reg, slot_next;
    logic        found_reg, found_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    frc_pkg::hrec_t cur_reg, cur_next;     // record held at i
    frc_pkg::hrec_t oth_reg, oth_next;     // record held at j
    frc_pkg::hrec_t best_reg, best_next;
    logic [FW-1:0] bidx_reg, bidx_next;
    logic        hit_reg, hit_next, ev_reg, ev_next;
    frc_pkg::slot_t evs_reg, evs_next;
    logic [31:0] rdata_reg, rdata_next;
    logic        mvalid_reg;
    logic [103:0] mdata_reg;

    logic        h_we, s_we;
    logic [IW-1:0] h_wa, h_ra, s_wa, s_ra;
    frc_pkg::hrec_t h_wd, h_rd;
    frc_pkg::slot_t s_wd, s_rd;

    frc_ram #(.DEPTH(frc_pkg::CAPACITY), .WIDTH(HW)) u_heap (
        .aclk(aclk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
    );

    frc_ram #(.DEPTH(frc_pkg::CAPACITY), .WIDTH(SW)) u_slot (
        .aclk(aclk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
    );

    logic mx;
    assign mx = (policy_reg == frc_pkg::POL_MFU) || (policy_reg == frc_pkg::POL_MFRU);

    logic [FW:0] lc;                        // 2*i+1
    assign lc = {i_reg, 1'b1};

    assign s_axis_tready = aresetn && (state_reg == frc_pkg::ST_IDLE) && !mvalid_reg;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= frc_pkg::ST_IDLE;
            policy_reg <= frc_pkg::POL_LFU;
            fill_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_we) begin
                policy_reg <= cfg_wdata;
            end
            if (state_reg == frc_pkg::ST_OUT) begin
                mvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            cmd_reg   <= s_axis_tdata[1:0];
            addr_reg  <= s_axis_tdata[33:2];
            wdata_reg <= s_axis_tdata[65:34];
        end
        i_reg     <= i_next;
        j_reg     <= j_next;
        h_reg     <= h_next;
        slot_reg  <= slot_next;
        found_reg <= found_next;
        cnt_reg   <= cnt_next;
        cur_reg   <= cur_next;
        oth_reg   <= oth_next;
        best_reg  <= best_next;
        bidx_reg  <= bidx_next;
        hit_reg   <= hit_next;
        ev_reg    <= ev_next;
        evs_reg   <= evs_next;
        rdata_reg <= rdata_next;
        if (state_reg == frc_pkg::ST_OUT) begin
            mdata_reg <= {5'd0, evs_reg.dirty, evs_reg.data, evs_reg.address, ev_reg,
                          rdata_reg, hit_reg};
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            frc_pkg::ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    state_next = (s_axis_tdata[1:0] == frc_pkg::CMD_UNUSED)
                                 ? frc_pkg::ST_OUT : frc_pkg::ST_SRCH_RD;
                end
            end
            frc_pkg::ST_SRCH_RD: begin
                state_next = (i_reg < fill_reg) ? frc_pkg::ST_SRCH_CHK : frc_pkg::ST_SLOT_WR;
            end
            frc_pkg::ST_SRCH_CHK: begin
                if (s_rd.address == addr_reg) begin
                    state_next = frc_pkg::ST_HFIND_RD;
                end else begin
                    state_next = frc_pkg::ST_SRCH_RD;
                end
            end
            frc_pkg::ST_HFIND_RD:  state_next = frc_pkg::ST_HFIND_CHK;
            frc_pkg::ST_HFIND_CHK: begin
                if (h_rd.hslot == slot_reg || i_reg + 1'b1 >= fill_reg) begin
                    state_next = frc_pkg::ST_DEL_RD;
                end else begin
                    state_next = frc_pkg::ST_HFIND_RD;
                end
            end
            frc_pkg::ST_VIC_RD:  state_next = frc_pkg::ST_VIC_CHK;
            frc_pkg::ST_VIC_CHK: begin
                state_next = (i_reg + 1'b1 >= fill_reg) ? frc_pkg::ST_VSLOT_RD
                                                        : frc_pkg::ST_VIC_RD;
            end
            frc_pkg::ST_VSLOT_RD:  state_next = frc_pkg::ST_VSLOT_CHK;
            frc_pkg::ST_VSLOT_CHK: state_next = frc_pkg::ST_DEL_RD;
            frc_pkg::ST_DEL_RD:    state_next = frc_pkg::ST_DEL_WR;
            frc_pkg::ST_DEL_WR:    state_next = frc_pkg::ST_SD_RD;
            frc_pkg::ST_SD_RD: begin
                state_next = (lc < {1'b0, fill_reg}) ? frc_pkg::ST_SD_RD2
                                                     : frc_pkg::ST_AGE_RD;
            end
            frc_pkg::ST_SD_RD2:  state_next = frc_pkg::ST_SD_CHK;
            frc_pkg::ST_SD_CHK:  state_next = frc_pkg::ST_SD_RD3;
            frc_pkg::ST_SD_RD3:  state_next = frc_pkg::ST_SD_SWAP;
            frc_pkg::ST_SD_SWAP: begin
                state_next = (mx ? (cur_reg.count <= oth_reg.count)
                                 : (cur_reg.count >= oth_reg.count)) ? frc_pkg::ST_SD_RD
                                                                     : frc_pkg::ST_AGE_RD;
            end
            frc_pkg::ST_AGE_RD: begin
                state_next = (i_reg < fill_reg) ? frc_pkg::ST_AGE_WR : frc_pkg::ST_INS_WR;
            end
            frc_pkg::ST_AGE_WR: state_next = frc_pkg::ST_AGE_RD;
            frc_pkg::ST_INS_WR: state_next = frc_pkg::ST_SU_RD;
            frc_pkg::ST_SU_RD: begin
                state_next = (i_reg == '0) ? frc_pkg::ST_SLOT_WR : frc_pkg::ST_SU_RD2;
            end
            frc_pkg::ST_SU_RD2: state_next = frc_pkg::ST_SU_CHK;
            frc_pkg::ST_SU_CHK: begin
                state_next = (mx ? (cur_reg.count > h_rd.count)
                                 : (cur_reg.count < h_rd.count)) ? frc_pkg::ST_SU_RD
                                                                 : frc_pkg::ST_SLOT_WR;
            end
            frc_pkg::ST_SLOT_WR: state_next = frc_pkg::ST_OUT;
            frc_pkg::ST_OUT:     state_next = frc_pkg::ST_IDLE;
            default:             state_next = frc_pkg::ST_IDLE;
        endcase
        // a miss with no hit found: decide between fill, evict or nothing
        if (state_reg == frc_pkg::ST_SRCH_RD && !(i_reg < fill_reg)) begin
            if (cmd_reg == frc_pkg::CMD_READ) begin
                state_next = frc_pkg::ST_OUT;
            end else if (fill_reg < CAP) begin
                state_next = frc_pkg::ST_AGE_RD;
            end else if (policy_reg == frc_pkg::POL_MFRU || policy_reg == frc_pkg::POL_LFRU) begin
                state_next = frc_pkg::ST_VIC_RD;
            end else begin
                state_next = frc_pkg::ST_VSLOT_RD;
            end
        end
    end

    // datapath and memory control
    always_comb begin
        fill_next  = fill_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        h_next     = h_reg;
        slot_next  = slot_reg;
        found_next = found_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        oth_next   = oth_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        hit_next   = hit_reg;
        ev_next    = ev_reg;
        evs_next   = evs_reg;
        rdata_next = rdata_reg;
        h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = i_reg[IW-1:0];
        s_we = 1'b0; s_wa = slot_reg; s_wd = '0; s_ra = i_reg[IW-1:0];
        case (state_reg)
            frc_pkg::ST_IDLE: begin
                i_next     = '0;
                found_next = 1'b0;
                hit_next   = 1'b0;
                ev_next    = 1'b0;
                evs_next   = '0;
                rdata_next = '0;
                cnt_next   = CW'(1);
            end
            frc_pkg::ST_SRCH_RD: begin
                s_ra = i_reg[IW-1:0];
                if (!(i_reg < fill_reg)) begin
                    slot_next = fill_reg[IW-1:0];
                    i_next    = '0;
                    bidx_next = '0;
                end
            end
            frc_pkg::ST_SRCH_CHK: begin
                if (s_rd.address == addr_reg) begin
                    found_next = 1'b1;
                    hit_next   = 1'b1;
                    slot_next  = i_reg[IW-1:0];
                    if (cmd_reg == frc_pkg::CMD_READ) begin
                        rdata_next = s_rd.data;
                    end
                    evs_next   = '0;
                    i_next     = '0;
                    h_next     = '0;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            frc_pkg::ST_HFIND_RD: begin
                h_ra = i_reg[IW-1:0];
            end
            frc_pkg::ST_HFIND_CHK: begin
                if (h_rd.hslot == slot_reg) begin
                    h_next   = i_reg;
                    cnt_next = (h_rd.count < CNT_MAX) ? h_rd.count + 1'b1 : h_rd.count;
                end else begin
                    i_next = i_reg + 1'b1;
                    // record not found: keep position 0 as the model does
                    if (i_reg + 1'b1 >= fill_reg) begin
                        h_next = '0;
                    end
                end
            end
            frc_pkg::ST_VIC_RD: begin
                h_ra = i_reg[IW-1:0];
            end
            frc_pkg::ST_VIC_CHK: begin
                if (i_reg == '0) begin
                    best_next = h_rd;
                    bidx_next = '0;
                end else if (policy_reg == frc_pkg::POL_MFRU) begin
                    if (h_rd.count > best_reg.count
                        || (h_rd.count == best_reg.count && h_rd.age < best_reg.age)) begin
                        best_next = h_rd;
                        bidx_next = i_reg;
                    end
                end else begin
                    if (h_rd.count < best_reg.count
                        || (h_rd.count == best_reg.count && h_rd.age > best_reg.age)) begin
                        best_next = h_rd;
                        bidx_next = i_reg;
                    end
                end
                i_next = i_reg + 1'b1;
            end
            frc_pkg::ST_VSLOT_RD: begin
                h_ra = bidx_reg[IW-1:0];
                h_next = bidx_reg;
            end
            frc_pkg::ST_VSLOT_CHK: begin
                slot_next = h_rd.hslot;
                ev_next   = 1'b1;
            end
            frc_pkg::ST_DEL_RD: begin
                // read the last record; for evictions fetch the victim slot too
                h_ra = IW'(fill_reg - 1'b1);
                s_ra = slot_reg;
            end
            frc_pkg::ST_DEL_WR: begin
                if (ev_reg) begin
                    evs_next = s_rd;
                end
                h_we      = 1'b1;
                h_wa      = h_reg[IW-1:0];
                h_wd      = h_rd;
                cur_next  = h_rd;
                fill_next = fill_reg - 1'b1;
                i_next    = h_reg;
            end
            frc_pkg::ST_SD_RD: begin
                h_ra = lc[IW-1:0];
                j_next = lc[FW-1:0];
            end
            frc_pkg::ST_SD_RD2: begin
                oth_next = h_rd;
                h_ra = IW'(j_reg + 1'b1);
            end
            frc_pkg::ST_SD_CHK: begin
                if (j_reg + 1'b1 < fill_reg
                    && (mx ? (h_rd.count >= oth_reg.count) : (h_rd.count < oth_reg.count))) begin
                    oth_next = h_rd;
                    j_next   = j_reg + 1'b1;
                end
            end
            frc_pkg::ST_SD_RD3: begin
                h_ra = i_reg[IW-1:0];
            end
            frc_pkg::ST_SD_SWAP: begin
                cur_next = h_rd;
                if (mx ? (cur_reg.count <= oth_reg.count) : (cur_reg.count >= oth_reg.count)) begin
                    // i gets child now; child written on the next pass or at the end
                    h_we = 1'b1;
                    h_wa = i_reg[IW-1:0];
                    h_wd = oth_reg;
                    i_next = j_reg;
                end else begin
                    i_next = '0;
                end
                if (!(mx ? (cur_reg.count <= oth_reg.count)
                         : (cur_reg.count >= oth_reg.count))) begin
                    i_next = '0;
                end
            end
            frc_pkg::ST_AGE_RD: begin
                h_ra = i_reg[IW-1:0];
                // after sift down, the sifted record was already written back at its final spot
            end
            frc_pkg::ST_AGE_WR: begin
                h_we = 1'b1;
                h_wa = i_reg[IW-1:0];
                h_wd = h_rd;
                if (h_rd.age != '1) begin
                    h_wd.age = h_rd.age + 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            frc_pkg::ST_INS_WR: begin
                cur_next.hslot = slot_reg;
                cur_next.count = cnt_reg;
                cur_next.age   = '0;
                h_we = 1'b1;
                h_wa = fill_reg[IW-1:0];
                h_wd = cur_next;
                i_next    = fill_reg;
                fill_next = fill_reg + 1'b1;
            end
            frc_pkg::ST_SU_RD: begin
                j_next = (i_reg - 1'b1) >> 1;
            end
            frc_pkg::ST_SU_RD2: begin
                h_ra = j_reg[IW-1:0];
            end
            frc_pkg::ST_SU_CHK: begin
                if (mx ? (cur_reg.count > h_rd.count) : (cur_reg.count < h_rd.count)) begin
                    h_we = 1'b1;
                    h_wa = i_reg[IW-1:0];
                    h_wd = h_rd;
                    i_next = j_reg;
                end
            end
            frc_pkg::ST_SLOT_WR: begin
                if (cmd_reg != frc_pkg::CMD_READ) begin
                    s_we = 1'b1;
                    s_wa = slot_reg;
                    s_wd.address = addr_reg;
                    s_wd.data    = wdata_reg;
                    s_wd.dirty   = (cmd_reg == frc_pkg::CMD_WRITE);
                end
                // write the record at its final sift-up position
                if (found_reg || cmd_reg != frc_pkg::CMD_READ) begin
                    h_we = 1'b1;
                    h_wa = i_reg[IW-1:0];
                    h_wd = cur_reg;
                end
            end
            default: ;
        endcase
        // leaving sift down: park the record at i, then start the ageing pass at 0
        if ((state_reg == frc_pkg::ST_SD_RD && !(lc < {1'b0, fill_reg}))
            || (state_reg == frc_pkg::ST_SD_SWAP
                && !(mx ? (cur_reg.count <= oth_reg.count)
                        : (cur_reg.count >= oth_reg.count)))) begin
            h_we = 1'b1;
            h_wa = i_reg[IW-1:0];
            h_wd = cur_reg;
            i_next = '0;
        end
        if (state_reg == frc_pkg::ST_SD_SWAP) begin
            cur_next = cur_reg;
        end
    end

endmodule

`default_nettype wire

### design/frc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module frc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CAP = frc_pkg::CAPACITY;
    localparam int IW  = frc_pkg::IDX_W;
    localparam int CW  = frc_pkg::COUNT_WIDTH;

    typedef struct packed {
        logic        ev_dirty;
        logic [31:0] ev_data;
        logic [31:0] ev_addr;
        logic        evicted;
        logic [31:0] rdata;
        logic        hit;
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_wdata = '0;

    frequency_replacement_cache_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    logic [1:0]    pol;
    logic [31:0]   c_addr [CAP];
    logic [31:0]   c_data [CAP];
    logic          c_dirty [CAP];
    logic [IW-1:0] h_slot [CAP];
    logic [CW-1:0] h_cnt [CAP];
    logic [31:0]   h_age [CAP];
    int            fill;

    outcome_t pending[$];
    int       errors = 0;
    int       cycles = 0;
    int       rdy_hold = 0;
    bit       drain_done = 1'b0;
    logic [31:0] addr_pool [8];

    function automatic bit top_first();
        return pol == frc_pkg::POL_MFU || pol == frc_pkg::POL_MFRU;
    endfunction

    function automatic void hswap(int a, int b);
        logic [IW-1:0] s;
        logic [CW-1:0] c;
        logic [31:0] g;
        s = h_slot[a]; h_slot[a] = h_slot[b]; h_slot[b] = s;
        c = h_cnt[a]; h_cnt[a] = h_cnt[b]; h_cnt[b] = c;
        g = h_age[a]; h_age[a] = h_age[b]; h_age[b] = g;
    endfunction

    function automatic void heap_remove(int idx);
        bit mx;
        int i, j;
        mx = top_first();
        hswap(idx, fill - 1);
        fill--;
        i = idx;
        j = 2 * i + 1;
        while (j < fill) begin
            if (j + 1 < fill)
                if (mx ? (h_cnt[j+1] >= h_cnt[j]) : (h_cnt[j+1] < h_cnt[j])) j++;
            if (mx ? (h_cnt[i] <= h_cnt[j]) : (h_cnt[i] >= h_cnt[j])) begin
                hswap(i, j);
                i = j;
                j = 2 * i + 1;
            end else break;
        end
    endfunction

    function automatic void heap_add(int slot, logic [CW-1:0] cnt);
        bit mx;
        int i, p;
        mx = top_first();
        for (i = 0; i < fill; i++) if (h_age[i] != '1) h_age[i]++;
        i = fill;
        h_slot[i] = IW'(slot);
        h_cnt[i] = cnt;
        h_age[i] = '0;
        fill++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (mx ? (h_cnt[i] > h_cnt[p]) : (h_cnt[i] < h_cnt[p])) begin
                hswap(i, p);
                i = p;
            end else break;
        end
    endfunction

    function automatic int choose_victim();
        logic [CW-1:0] best;
        logic [31:0] oldest;
        int found, i;
        found = 0;
        if (pol == frc_pkg::POL_LFU || pol == frc_pkg::POL_MFU) return 0;
        best = h_cnt[0];
        oldest = h_age[0];
        for (i = 0; i < fill; i++) begin
            if (pol == frc_pkg::POL_MFRU) begin
                if (h_cnt[i] > best) begin
                    best = h_cnt[i]; oldest = h_age[i]; found = i;
                end else if (h_cnt[i] == best && h_age[i] < oldest) begin
                    oldest = h_age[i]; found = i;
                end
            end else begin
                if (h_cnt[i] < best) begin
                    best = h_cnt[i]; oldest = h_age[i]; found = i;
                end else if (h_cnt[i] == best && h_age[i] > oldest) begin
                    oldest = h_age[i]; found = i;
                end
            end
        end
        return found;
    endfunction

    function automatic outcome_t cache_access(logic [1:0] cmd, logic [31:0] addr,
                                              logic [31:0] wdata);
        outcome_t r;
        int i, slot, h;
        bit found;
        logic [CW-1:0] cnt;
        r = '0;
        found = 0;
        slot = 0;
        h = 0;
        if (cmd == frc_pkg::CMD_UNUSED) return r;
        for (i = 0; i < fill; i++)
            if (!found && c_addr[i] == addr) begin
                slot = i; found = 1;
            end
        if (found) begin
            r.hit = 1'b1;
            for (i = fill - 1; i >= 0; i--) if (int'(h_slot[i]) == slot) h = i;
            cnt = h_cnt[h];
            if (cnt != '1) cnt++;
            if (cmd == frc_pkg::CMD_READ) r.rdata = c_data[slot];
            else begin
                c_data[slot] = wdata;
                c_dirty[slot] = (cmd == frc_pkg::CMD_WRITE);
            end
            heap_remove(h);
            heap_add(slot, cnt);
            return r;
        end
        if (cmd == frc_pkg::CMD_READ) return r;
        if (fill < CAP) slot = fill;
        else begin
            h = choose_victim();
            slot = int'(h_slot[h]);
            r.evicted = 1'b1;
            r.ev_addr = c_addr[slot];
            r.ev_data = c_data[slot];
            r.ev_dirty = c_dirty[slot];
            heap_remove(h);
        end
        c_addr[slot] = addr;
        c_data[slot] = wdata;
        c_dirty[slot] = (cmd == frc_pkg::CMD_WRITE);
        heap_add(slot, CW'(1));
        return r;
    endfunction

    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n + 1) @(negedge aclk);
    endtask

    task automatic send_request(logic [1:0] cmd, logic [31:0] addr, logic [31:0] wdata);
        pause_random();
        s_axis_tdata <= {6'd0, wdata, addr, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending.push_back(cache_access(cmd, addr, wdata));
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    task automatic set_policy(logic [1:0] p);
        drain();
        cfg_wdata <= p;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        pol = p;
    endtask

    always @(negedge aclk) begin
        if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            rdy_hold <= $urandom_range(10, 60);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        outcome_t got, want;
        cycles <= cycles + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[98:0];
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                want = pending.pop_front();
                if (got.hit !== want.hit)
                    $error("hit exp %0h got %0h", want.hit, got.hit);
                if (got.rdata !== want.rdata)
                    $error("rdata exp %0h got %0h", want.rdata, got.rdata);
                if (got.evicted !== want.evicted)
                    $error("evicted exp %0h got %0h", want.evicted, got.evicted);
                if (got.ev_addr !== want.ev_addr)
                    $error("evict_address exp %0h got %0h", want.ev_addr, got.ev_addr);
                if (got.ev_data !== want.ev_data)
                    $error("evict_data exp %0h got %0h", want.ev_data, got.ev_data);
                if (got.ev_dirty !== want.ev_dirty)
                    $error("evict_dirty exp %0h got %0h", want.ev_dirty, got.ev_dirty);
                if (got !== want) errors++;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > 3000000 && !drain_done) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed();
        int i;
        send_request(frc_pkg::CMD_READ, 32'h0, 32'h0);
        send_request(frc_pkg::CMD_PUT, 32'h0, 32'hFFFF_FFFF);
        send_request(frc_pkg::CMD_READ, 32'h0, 32'h0);
        send_request(frc_pkg::CMD_WRITE, 32'hFFFF_FFFF, 32'h0);
        send_request(frc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(frc_pkg::CMD_WRITE, 32'h0, 32'hA5A5_5A5A);
        send_request(frc_pkg::CMD_UNUSED, 32'h0, 32'h0);
        for (i = 0; i < 16; i++)
            send_request(i[0] ? frc_pkg::CMD_WRITE : frc_pkg::CMD_PUT, 32'h100 + i, $urandom);
        send_request(frc_pkg::CMD_READ, 32'h105, 32'h0);
        send_request(frc_pkg::CMD_READ, 32'h7777_7777, 32'h0);
    endtask

    task automatic test_random(int n);
        int i, k;
        logic [1:0] cmd;
        logic [31:0] addr;
        for (k = 0; k < 8; k++) addr_pool[k] = $urandom;
        for (i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            cmd = (k < 40) ? frc_pkg::CMD_READ : (k < 65) ? frc_pkg::CMD_PUT :
                  (k < 97) ? frc_pkg::CMD_WRITE : frc_pkg::CMD_UNUSED;
            k = $urandom_range(0, 9);
            addr = (k < 7) ? 32'h200 + $urandom_range(0, 23) :
                   (k < 9) ? addr_pool[$urandom_range(0, 7)] : $urandom;
            send_request(cmd, addr, $urandom);
        end
    endtask

    task automatic test_hot_entries(int n);
        int i;
        for (i = 0; i < n; i++)
            send_request(($urandom_range(0, 2) == 0) ? frc_pkg::CMD_PUT : frc_pkg::CMD_READ,
                         32'h300 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                                 : $urandom_range(0, 3)),
                         $urandom);
    endtask

    initial begin
        pol = frc_pkg::POL_LFU;
        fill = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        set_policy(frc_pkg::POL_MFU);
        test_random(350);
        drain();
        set_policy(frc_pkg::POL_MFRU);
        test_random(350);
        test_hot_entries(100);
        set_policy(frc_pkg::POL_LFRU);
        test_random(350);
        test_hot_entries(100);
        set_policy(frc_pkg::POL_LFU);
        test_random(300);
        set_policy(frc_pkg::POL_MFRU);
        test_random(100);
        drain();
        drain_done = 1'b1;
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
